[rtl/ddm_pkg.sv]
// Shared package for the differential drive mixer: field widths, reset values,
// sign codes, register indexes and the structs passed between blocks.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ddm_pkg;

  // Field and register widths
  localparam int CMD_W        = 16;
  localparam int FIELD_W      = 10;
  localparam int TRIM_W       = 15;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 15;
  localparam int PWM_BITS_DEF = 10;

  // Mixing arithmetic
  localparam int ONE_Q14_SHIFT = 14;
  localparam int FRAC_Q28      = 28;
  localparam int TRIM_FRAC     = 14;
  localparam int PROD_W        = 2 * CMD_W + 1;       // y * (1 +- x), signed
  localparam int MAG_W         = 31;                  // largest magnitude < 2^31
  localparam int Q_BITS        = FRAC_Q28 + 1;        // quotient up to 1.0 in Q28
  localparam int DIFF_W        = FIELD_W + 1;         // pwm_max - pwm_min, signed
  localparam int MAP_W         = DIFF_W + MAG_W + 1;  // diff * magnitude, signed
  localparam int SUM_W         = 18;                  // mapped duty before clamp

  localparam logic [MAG_W-1:0]        MAG_ONE = MAG_W'(1) << FRAC_Q28;
  localparam logic signed [CMD_W:0]   ONE_Q14 = (CMD_W + 1)'(1 << ONE_Q14_SHIFT);

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Register reset values
  localparam logic [FIELD_W-1:0] PWM_MIN_RST   = FIELD_W'(0);
  localparam logic [FIELD_W-1:0] PWM_MAX_RST   = FIELD_W'(1023);
  localparam logic [TRIM_W-1:0]  LEFT_TRIM_RST = TRIM_W'(16384);

  // Register indexes on the configuration channel
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PWM_MIN   = 2'd0,
    CFG_PWM_MAX   = 2'd1,
    CFG_LEFT_TRIM = 2'd2
  } cfg_idx_t;

  // Sign of a mixed motor value
  typedef enum logic [1:0] {
    SGN_ZERO = 2'd0,
    SGN_POS  = 2'd1,
    SGN_NEG  = 2'd2
  } sgn_t;

  typedef struct packed {
    logic [FIELD_W-1:0] pwm_min;
    logic [FIELD_W-1:0] pwm_max;
    logic [TRIM_W-1:0]  left_trim;
  } cfg_t;

  // One classified command as it sits in the queue
  typedef struct packed {
    logic [MAG_W-1:0] mag_r;
    logic [MAG_W-1:0] mag_l;
    sgn_t             sgn_r;
    sgn_t             sgn_l;
    logic             norm;   // scale both magnitudes by the larger one
    logic             r_big;  // right magnitude is the larger one
  } mix_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

[rtl/ddm_ifs.sv]
// Valid/ready channel interfaces: drive command in, pin duties out, and the
// configuration write channel. Depends on ddm_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ddm_cmd_if import ddm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [CMD_W-1:0] speed_y;
  logic signed [CMD_W-1:0] turn_x;

  modport source (output valid, speed_y, turn_x, input ready);
  modport sink   (input valid, speed_y, turn_x, output ready);
endinterface

interface ddm_pwm_if import ddm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] right_fwd_pwm;
  logic [FIELD_W-1:0] right_rev_pwm;
  logic [FIELD_W-1:0] left_fwd_pwm;
  logic [FIELD_W-1:0] left_rev_pwm;

  modport source (output valid, right_fwd_pwm, right_rev_pwm, left_fwd_pwm, left_rev_pwm,
                  input ready);
  modport sink   (input valid, right_fwd_pwm, right_rev_pwm, left_fwd_pwm, left_rev_pwm,
                  output ready);
endinterface

interface ddm_cfg_if import ddm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/ddm_front.sv]
// Front end: accepts drive commands, forms the mixed products and classifies
// each command (signs, magnitudes, normalize flag) for the queue.
// Depends on ddm_pkg and ddm_ifs.
`timescale 1ns / 1ps
`default_nettype none

module ddm_front import ddm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  ddm_cmd_if.sink   cmd,
  input  q_status_t q_stat,
  output logic      push,
  output mix_t      push_ent
);

  logic                     f_vld;
  logic                     f_spin;
  logic signed [PROD_W-1:0] f_r;
  logic signed [PROD_W-1:0] f_l;

  logic                     accept;
  logic                     spin;
  logic signed [CMD_W:0]    x_m;
  logic signed [CMD_W:0]    x_p;
  logic signed [PROD_W-1:0] y_ext;
  logic signed [PROD_W-1:0] x_sh;
  logic signed [PROD_W-1:0] mul_r;
  logic signed [PROD_W-1:0] mul_l;

  logic [PROD_W-1:0] abs_r;
  logic [PROD_W-1:0] abs_l;
  logic [MAG_W-1:0]  mag_r;
  logic [MAG_W-1:0]  mag_l;
  logic              r_big;
  logic [MAG_W-1:0]  mag_max;

  function automatic sgn_t sign_of(input logic signed [PROD_W-1:0] v);
    sgn_t s;
    if (v == '0) begin
      s = SGN_ZERO;
    end else if (v[PROD_W-1]) begin
      s = SGN_NEG;
    end else begin
      s = SGN_POS;
    end
    return s;
  endfunction

  // Handshake: hold the staged command while the queue is full
  assign accept    = cmd.valid && cmd.ready;
  assign cmd.ready = !f_vld || !q_stat.full;
  assign push      = f_vld && !q_stat.full;

  // Mixed products y*(1-x), y*(1+x); spin in place uses +-x in Q28
  assign spin  = (cmd.speed_y == '0);
  assign x_m   = ONE_Q14 - (CMD_W + 1)'(cmd.turn_x);
  assign x_p   = ONE_Q14 + (CMD_W + 1)'(cmd.turn_x);
  assign y_ext = PROD_W'(cmd.speed_y);
  assign mul_r = y_ext * PROD_W'(x_m);
  assign mul_l = y_ext * PROD_W'(x_p);
  assign x_sh  = PROD_W'(cmd.turn_x) <<< ONE_Q14_SHIFT;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else if (accept) begin
      f_vld <= 1'b1;
    end else if (push) begin
      f_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_spin <= spin;
      f_r    <= spin ? -x_sh : mul_r;
      f_l    <= spin ? x_sh : mul_l;
    end
  end

  // Classification of the staged command
  assign abs_r   = f_r[PROD_W-1] ? PROD_W'(-f_r) : PROD_W'(f_r);
  assign abs_l   = f_l[PROD_W-1] ? PROD_W'(-f_l) : PROD_W'(f_l);
  assign mag_r   = abs_r[MAG_W-1:0];
  assign mag_l   = abs_l[MAG_W-1:0];
  assign r_big   = (mag_r >= mag_l);
  assign mag_max = r_big ? mag_r : mag_l;

  always_comb begin
    push_ent       = '0;
    push_ent.mag_r = mag_r;
    push_ent.mag_l = mag_l;
    push_ent.sgn_r = sign_of(f_r);
    push_ent.sgn_l = sign_of(f_l);
    push_ent.norm  = !f_spin && (mag_max > MAG_ONE);
    push_ent.r_big = r_big;
  end

endmodule

`default_nettype wire

[rtl/ddm_queue.sv]
// Small FIFO of classified commands between the front and the back end.
// Depends on ddm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ddm_queue import ddm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  mix_t      push_ent,
  input  logic      pop,
  output mix_t      head,
  output q_status_t q_stat
);

  mix_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign q_stat.full  = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign q_stat.empty = (count == '0);
  assign head         = slots[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_ent;
    end
  end

endmodule

`default_nettype wire

[rtl/ddm_back.sv]
// Back end: restoring-division pipeline for normalization, duty mapping,
// left trim and pin selection, ending in the output register.
// Depends on ddm_pkg and ddm_ifs.
`timescale 1ns / 1ps
`default_nettype none

module ddm_back import ddm_pkg::*; #(
  parameter int PWM_BITS = PWM_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  mix_t      q_head,
  input  q_status_t q_stat,
  output logic      pop,
  ddm_pwm_if.source pwm
);

  localparam int TRIM_PROD_W = PWM_BITS + TRIM_W;
  localparam logic [SUM_W-1:0]    FULL_SUM  = SUM_W'((1 << PWM_BITS) - 1);
  localparam logic [PWM_BITS:0]   FULL_TRIM = (PWM_BITS + 1)'((1 << PWM_BITS) - 1);
  localparam logic [PWM_BITS-1:0] FULL_DUTY = '1;

  // Whole pipeline moves when the output register can take a transaction
  logic adv;

  logic                   div_vld [Q_BITS];
  logic [MAG_W-1:0]       div_rem [Q_BITS];
  logic [Q_BITS-1:0]      div_quo [Q_BITS];
  mix_t                   div_ent [Q_BITS];

  logic                    a_vld;
  sgn_t                    a_sgn_r;
  sgn_t                    a_sgn_l;
  logic signed [MAP_W-1:0] a_prod_r;
  logic signed [MAP_W-1:0] a_prod_l;

  logic                     b_vld;
  sgn_t                     b_sgn_r;
  sgn_t                     b_sgn_l;
  logic [PWM_BITS-1:0]      b_duty_r;
  logic [TRIM_PROD_W-1:0]   b_trim;

  logic               o_vld;
  logic [FIELD_W-1:0] o_rf;
  logic [FIELD_W-1:0] o_rr;
  logic [FIELD_W-1:0] o_lf;
  logic [FIELD_W-1:0] o_lr;

  mix_t                     last_ent;
  logic [MAG_W-1:0]         sel_r;
  logic [MAG_W-1:0]         sel_l;
  logic [MAG_W-1:0]         quo_ext;
  logic signed [DIFF_W-1:0] diff;
  logic [PWM_BITS-1:0]      duty_l;
  logic [PWM_BITS:0]        trim_sh;
  logic [PWM_BITS-1:0]      duty_l_trim;

  // pwm_min + trunc(prod / 2^28), clamped to the duty range
  function automatic logic [PWM_BITS-1:0] map_clamp(input logic signed [MAP_W-1:0] p,
                                                    input logic [FIELD_W-1:0] base);
    logic [MAP_W-1:0]        ap;
    logic [SUM_W-1:0]        q;
    logic signed [SUM_W-1:0] sum;
    logic [PWM_BITS-1:0]     d;
    ap  = p[MAP_W-1] ? MAP_W'(-p) : MAP_W'(p);
    q   = SUM_W'(ap >> FRAC_Q28);
    sum = p[MAP_W-1] ? -$signed(q) : $signed(q);
    sum = sum + $signed(SUM_W'(base));
    if (sum[SUM_W-1]) begin
      d = '0;
    end else if (sum > $signed(FULL_SUM)) begin
      d = FULL_DUTY;
    end else begin
      d = sum[PWM_BITS-1:0];
    end
    return d;
  endfunction

  // Duty into the 10-bit pin field
  function automatic logic [FIELD_W-1:0] to_field(input logic [PWM_BITS-1:0] d);
    logic [PWM_BITS+FIELD_W-1:0] e;
    e = {{FIELD_W{1'b0}}, d};
    return e[FIELD_W-1:0];
  endfunction

  assign adv = !o_vld || pwm.ready;
  assign pop = adv && !q_stat.empty;

  // Quotient small * 2^28 / large, one bit per stage, MSB first
  for (genvar i = 0; i < Q_BITS; i++) begin : g_div
    mix_t              ent_in;
    logic              vld_in;
    logic [Q_BITS-1:0] quo_in;
    logic [MAG_W:0]    trial;
    logic [MAG_W:0]    dvsr;
    logic [MAG_W:0]    dif;
    logic              fit;

    if (i == 0) begin : g_first
      assign ent_in = q_head;
      assign vld_in = pop;
      assign quo_in = '0;
      assign trial  = {1'b0, q_head.r_big ? q_head.mag_l : q_head.mag_r};
    end else begin : g_next
      assign ent_in = div_ent[i-1];
      assign vld_in = div_vld[i-1];
      assign quo_in = div_quo[i-1];
      assign trial  = {div_rem[i-1], 1'b0};
    end

    assign dvsr = {1'b0, ent_in.r_big ? ent_in.mag_r : ent_in.mag_l};
    assign fit  = (trial >= dvsr);
    assign dif  = trial - dvsr;

    always_ff @(posedge clk) begin
      if (rst) begin
        div_vld[i] <= 1'b0;
      end else if (adv) begin
        div_vld[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        div_rem[i] <= fit ? dif[MAG_W-1:0] : trial[MAG_W-1:0];
        div_quo[i] <= {quo_in[Q_BITS-2:0], fit};
        div_ent[i] <= ent_in;
      end
    end
  end

  // Stage A: pick normalized magnitudes, multiply by the duty span
  assign last_ent = div_ent[Q_BITS-1];
  assign quo_ext  = MAG_W'(div_quo[Q_BITS-1]);
  assign sel_r    = !last_ent.norm ? last_ent.mag_r : (last_ent.r_big ? MAG_ONE : quo_ext);
  assign sel_l    = !last_ent.norm ? last_ent.mag_l : (last_ent.r_big ? quo_ext : MAG_ONE);
  assign diff     = $signed({1'b0, cfg.pwm_max}) - $signed({1'b0, cfg.pwm_min});

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (adv) begin
      a_vld <= div_vld[Q_BITS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_sgn_r  <= last_ent.sgn_r;
      a_sgn_l  <= last_ent.sgn_l;
      a_prod_r <= MAP_W'(diff) * MAP_W'($signed({1'b0, sel_r}));
      a_prod_l <= MAP_W'(diff) * MAP_W'($signed({1'b0, sel_l}));
    end
  end

  // Stage B: offset and clamp, left trim multiply
  assign duty_l = map_clamp(a_prod_l, cfg.pwm_min);

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (adv) begin
      b_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_sgn_r  <= a_sgn_r;
      b_sgn_l  <= a_sgn_l;
      b_duty_r <= map_clamp(a_prod_r, cfg.pwm_min);
      b_trim   <= TRIM_PROD_W'(duty_l) * TRIM_PROD_W'(cfg.left_trim);
    end
  end

  // Stage C: trim scaling and saturation, pin select into the output register
  assign trim_sh     = (PWM_BITS + 1)'(b_trim >> TRIM_FRAC);
  assign duty_l_trim = (trim_sh > FULL_TRIM) ? FULL_DUTY : trim_sh[PWM_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      o_vld <= 1'b0;
    end else if (adv) begin
      o_vld <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_rf <= (b_sgn_r == SGN_POS) ? to_field(b_duty_r) : '0;
      o_rr <= (b_sgn_r == SGN_NEG) ? to_field(b_duty_r) : '0;
      o_lf <= (b_sgn_l == SGN_POS) ? to_field(duty_l_trim) : '0;
      o_lr <= (b_sgn_l == SGN_NEG) ? to_field(duty_l_trim) : '0;
    end
  end

  assign pwm.valid         = o_vld;
  assign pwm.right_fwd_pwm = o_rf;
  assign pwm.right_rev_pwm = o_rr;
  assign pwm.left_fwd_pwm  = o_lf;
  assign pwm.left_rev_pwm  = o_lr;

endmodule

`default_nettype wire

[rtl/differential_drive_mixer_pwm_core.sv]
// Top level of the differential drive mixer: configuration registers and the
// front end, queue and back end. Depends on ddm_pkg, ddm_ifs and the ddm_* modules.
`timescale 1ns / 1ps
`default_nettype none

// Mixes a Q1.14 speed and turn command into left and right H-bridge pin
// duties. One command is taken per clock unless the queue is full, and each
// command produces one transaction of four duties. The path runs through the
// 29-stage restoring divider that normalizes the smaller motor magnitude by
// the larger one, one quotient bit per stage, plus one front stage, the queue
// and three stages of duty mapping, trim and pin selection. A four-entry queue
// separates the front from the back so each side stalls on its own.
// Configuration writes are taken every cycle and should only be issued while
// no command is in flight.

module differential_drive_mixer_pwm_core import ddm_pkg::*; #(
  parameter int PWM_BITS = PWM_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  ddm_cmd_if.sink   cmd,
  ddm_cfg_if.sink   cfg,
  ddm_pwm_if.source pwm
);

  cfg_t      cfg_regs;
  logic      push;
  logic      pop;
  mix_t      push_ent;
  mix_t      q_head;
  q_status_t q_stat;

  // Configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.pwm_min   <= PWM_MIN_RST;
      cfg_regs.pwm_max   <= PWM_MAX_RST;
      cfg_regs.left_trim <= LEFT_TRIM_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_PWM_MIN:   cfg_regs.pwm_min   <= cfg.data[FIELD_W-1:0];
        CFG_PWM_MAX:   cfg_regs.pwm_max   <= cfg.data[FIELD_W-1:0];
        CFG_LEFT_TRIM: cfg_regs.left_trim <= cfg.data[TRIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ddm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .q_stat   (q_stat),
    .push     (push),
    .push_ent (push_ent)
  );

  ddm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_ent (push_ent),
    .pop      (pop),
    .head     (q_head),
    .q_stat   (q_stat)
  );

  ddm_back #(
    .PWM_BITS (PWM_BITS)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_regs),
    .q_head (q_head),
    .q_stat (q_stat),
    .pop    (pop),
    .pwm    (pwm)
  );

endmodule

`default_nettype wire

[rtl/ddm_checker.sv]
// Port-level checks for the differential drive mixer top level, attached
// with a bind. Depends on differential_drive_mixer_pwm_core and ddm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ddm_checker import ddm_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               cmd_ready,
  input logic               pwm_valid,
  input logic               pwm_ready,
  input logic [FIELD_W-1:0] right_fwd_pwm,
  input logic [FIELD_W-1:0] right_rev_pwm,
  input logic [FIELD_W-1:0] left_fwd_pwm,
  input logic [FIELD_W-1:0] left_rev_pwm
);

  // Only one pin of each bridge is ever driven
  a_right_one_pin: assert property (@(posedge clk) disable iff (rst)
    pwm_valid |-> (right_fwd_pwm == '0 || right_rev_pwm == '0))
    else $error("right bridge drives both pins");

  a_left_one_pin: assert property (@(posedge clk) disable iff (rst)
    pwm_valid |-> (left_fwd_pwm == '0 || left_rev_pwm == '0))
    else $error("left bridge drives both pins");

  // A stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (pwm_valid && !pwm_ready) |=> (pwm_valid && $stable(right_fwd_pwm) &&
      $stable(right_rev_pwm) && $stable(left_fwd_pwm) && $stable(left_rev_pwm)))
    else $error("stalled result changed");

  // Reset empties the pipeline and opens the command side
  a_reset_clear: assert property (@(posedge clk)
    rst |=> (!pwm_valid && cmd_ready))
    else $error("state not cleared by reset");

endmodule

bind differential_drive_mixer_pwm_core ddm_checker u_ddm_checker (
  .clk           (clk),
  .rst           (rst),
  .cmd_ready     (cmd.ready),
  .pwm_valid     (pwm.valid),
  .pwm_ready     (pwm.ready),
  .right_fwd_pwm (pwm.right_fwd_pwm),
  .right_rev_pwm (pwm.right_rev_pwm),
  .left_fwd_pwm  (pwm.left_fwd_pwm),
  .left_rev_pwm  (pwm.left_rev_pwm)
);

`default_nettype wire

[tb/differential_drive_mixer_pwm_core_tb.sv]
// Self-checking testbench for differential_drive_mixer_pwm_core: drives speed/turn
// commands and register writes, predicts the four pin duties, checks each transaction.
// Depends on ddm_pkg, the ddm_*_if interfaces and the RTL of the mixer.
`timescale 1ns / 1ps

module differential_drive_mixer_pwm_core_tb;
  import ddm_pkg::*;

  localparam longint Q14_UNIT       = 64'sd1 << ONE_Q14_SHIFT;
  localparam longint Q28_UNIT       = 64'sd1 << FRAC_Q28;
  localparam longint DUTY_FULL      = (64'sd1 << PWM_BITS_DEF) - 1;
  localparam int     DRAIN_CYCLES   = 48;    // pipeline latency plus margin
  localparam int     WATCHDOG_LIMIT = 2000;  // cycles with no transaction at all
  localparam int     RANDOM_PHASES  = 6;
  localparam int     PHASE_COMMANDS = 110;
  localparam int     STREAM_COMMANDS = 90;

  // Index with no register behind it; writes to it must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  typedef struct packed {
    logic [FIELD_W-1:0] right_fwd;
    logic [FIELD_W-1:0] right_rev;
    logic [FIELD_W-1:0] left_fwd;
    logic [FIELD_W-1:0] left_rev;
  } pin_duties_t;

  logic clk;
  logic rst;

  ddm_cmd_if cmd_if ();
  ddm_cfg_if cfg_if ();
  ddm_pwm_if pwm_if ();

  differential_drive_mixer_pwm_core u_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if),
    .cfg (cfg_if),
    .pwm (pwm_if)
  );

  // Shadow copy of the registers, updated as each write is accepted
  logic [FIELD_W-1:0] cfg_pwm_min   = PWM_MIN_RST;
  logic [FIELD_W-1:0] cfg_pwm_max   = PWM_MAX_RST;
  logic [TRIM_W-1:0]  cfg_left_trim = LEFT_TRIM_RST;

  pin_duties_t expected_duties[$];
  int commands_sent    = 0;
  int duties_checked   = 0;
  int mismatch_count   = 0;
  int settings_applied = 0;
  bit cmd_gaps_on      = 1'b0;
  bit pwm_stalls_on    = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Duty predictor
  // ---------------------------------------------------------------------------

  function automatic longint clamp_duty(input longint d);
    if (d < 0) return 0;
    if (d > DUTY_FULL) return DUTY_FULL;
    return d;
  endfunction

  function automatic longint abs_q(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Linear map of a Q28 magnitude onto [pwm_min, pwm_max], truncated toward zero
  function automatic longint duty_from_mag(input longint mag);
    longint span;
    span = longint'(cfg_pwm_max) - longint'(cfg_pwm_min);
    return clamp_duty((span * mag) / Q28_UNIT + longint'(cfg_pwm_min));
  endfunction

  function automatic pin_duties_t predict_pin_duties(input logic signed [CMD_W-1:0] y,
                                                     input logic signed [CMD_W-1:0] x);
    longint sy, sx, r, l, mag_r, mag_l, peak, duty_r, duty_l;
    pin_duties_t d;
    sy = y;
    sx = x;
    duty_r = 0;
    duty_l = 0;
    if (sy == 0) begin
      // spin in place, no normalization
      l = sx;
      r = -sx;
      mag_l = abs_q(l) * Q14_UNIT;
      mag_r = abs_q(r) * Q14_UNIT;
    end else begin
      r = sy * (Q14_UNIT - sx);
      l = sy * (Q14_UNIT + sx);
      mag_r = abs_q(r);
      mag_l = abs_q(l);
      peak = (mag_r > mag_l) ? mag_r : mag_l;
      if (peak > Q28_UNIT) begin
        mag_r = (mag_r * Q28_UNIT) / peak;
        mag_l = (mag_l * Q28_UNIT) / peak;
      end
    end
    if (r != 0) duty_r = duty_from_mag(mag_r);
    if (l != 0) duty_l = clamp_duty((duty_from_mag(mag_l) * longint'(cfg_left_trim)) >>> TRIM_FRAC);
    d = '0;
    if (r > 0) d.right_fwd = duty_r[FIELD_W-1:0];
    else if (r < 0) d.right_rev = duty_r[FIELD_W-1:0];
    if (l > 0) d.left_fwd = duty_l[FIELD_W-1:0];
    else if (l < 0) d.left_rev = duty_l[FIELD_W-1:0];
    return d;
  endfunction

  // ---------------------------------------------------------------------------
  // Command and register channels
  // ---------------------------------------------------------------------------

  // Send one command; valid stays high into the next call unless a gap is taken
  task automatic send_command(input logic signed [CMD_W-1:0] y,
                              input logic signed [CMD_W-1:0] x);
    if (cmd_gaps_on && $urandom_range(0, 3) == 0) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    cmd_if.valid   <= 1'b1;
    cmd_if.speed_y <= y;
    cmd_if.turn_x  <= x;
    do @(posedge clk); while (!cmd_if.ready);
    expected_duties.push_back(predict_pin_duties(y, x));
    commands_sent++;
  endtask

  // Drop valid and hold off until every outstanding duty set has come back
  task automatic drain_commands();
    cmd_if.valid <= 1'b0;
    while (expected_duties.size() != 0) @(posedge clk);
  endtask

  // Leaves cfg valid high so back-to-back writes need one assignment per edge
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      CFG_PWM_MIN:   cfg_pwm_min   = value[FIELD_W-1:0];
      CFG_PWM_MAX:   cfg_pwm_max   = value[FIELD_W-1:0];
      CFG_LEFT_TRIM: cfg_left_trim = value[TRIM_W-1:0];
      default: ;
    endcase
  endtask

  // Write all three registers while idle; unused upper data bits are randomized
  task automatic configure(input int min_duty, input int max_duty, input int trim,
                           input bit poke_unused);
    drain_commands();
    write_register(CFG_PWM_MIN, {5'($urandom), 10'(min_duty)});
    write_register(CFG_PWM_MAX, {5'($urandom), 10'(max_duty)});
    write_register(CFG_LEFT_TRIM, 15'(trim));
    if (poke_unused) write_register(CFG_UNUSED_IDX, 15'($urandom));
    cfg_if.valid <= 1'b0;
    settings_applied++;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls and the checker
  // ---------------------------------------------------------------------------

  initial begin : pwm_ready_gen
    pwm_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (pwm_stalls_on && $urandom_range(0, 6) == 0) begin
        pwm_if.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      pwm_if.ready <= 1'b1;
    end
  end

  task automatic check_pin(input string name, input logic [FIELD_W-1:0] want,
                           input logic [FIELD_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    pin_duties_t want;
    if (!rst && pwm_if.valid && pwm_if.ready) begin
      if (expected_duties.size() == 0) begin
        $display("%0t: unexpected duty transaction, expected none, actual %0d/%0d/%0d/%0d",
                 $time, pwm_if.right_fwd_pwm, pwm_if.right_rev_pwm,
                 pwm_if.left_fwd_pwm, pwm_if.left_rev_pwm);
        mismatch_count++;
      end else begin
        want = expected_duties.pop_front();
        check_pin("right_fwd_pwm", want.right_fwd, pwm_if.right_fwd_pwm);
        check_pin("right_rev_pwm", want.right_rev, pwm_if.right_rev_pwm);
        check_pin("left_fwd_pwm",  want.left_fwd,  pwm_if.left_fwd_pwm);
        check_pin("left_rev_pwm",  want.left_rev,  pwm_if.left_rev_pwm);
        duties_checked++;
      end
    end
  end

  // Ends the run if no channel moves a transaction for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((cmd_if.valid && cmd_if.ready) || (cfg_if.valid && cfg_if.ready) ||
          (pwm_if.valid && pwm_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: watchdog expired with %0d duty sets outstanding", $time,
             expected_duties.size());
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Random command fields
  // ---------------------------------------------------------------------------

  function automatic logic signed [CMD_W-1:0] q14_in_range();
    return CMD_W'(int'($urandom_range(0, 32768)) - 16384);
  endfunction

  function automatic logic signed [CMD_W-1:0] q14_edge();
    case ($urandom_range(0, 7))
      0: return -16'sd16384;
      1: return 16'sd16384;
      2: return -16'sd1;
      3: return 16'sd1;
      4: return 16'sd16383;
      5: return -16'sd16383;
      6: return 16'sd0;
      default: return CMD_W'($urandom);
    endcase
  endfunction

  task automatic send_random_command();
    logic signed [CMD_W-1:0] y, x;
    case ($urandom_range(0, 9))
      0: begin  // spin in place
        y = '0;
        x = ($urandom_range(0, 3) == 0) ? CMD_W'($urandom) : q14_in_range();
      end
      1: begin  // anything the fields allow, mostly out of range
        y = CMD_W'($urandom);
        x = CMD_W'($urandom);
      end
      2: begin
        y = q14_edge();
        x = q14_edge();
      end
      3: begin  // tiny speeds
        y = CMD_W'(int'($urandom_range(0, 8)) - 4);
        x = q14_in_range();
      end
      default: begin
        y = q14_in_range();
        x = q14_in_range();
      end
    endcase
    send_command(y, x);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset register values with field extremes, spin, one motor exactly off
  task automatic test_reset_defaults();
    cmd_gaps_on   = 1'b1;
    pwm_stalls_on = 1'b1;
    send_command(16'sd0, 16'sd0);
    send_command(16'sd0, 16'sd16384);
    send_command(16'sd0, -16'sd16384);
    send_command(16'sd0, 16'sd32767);
    send_command(16'sd0, -16'sd32768);
    send_command(16'sd16384, 16'sd0);
    send_command(-16'sd16384, 16'sd0);
    send_command(16'sd16384, 16'sd16384);
    send_command(16'sd16384, -16'sd16384);
    send_command(-16'sd16384, 16'sd16384);
    send_command(16'sd1, 16'sd0);
    send_command(16'sd1, 16'sd16383);
    send_command(16'sd32767, 16'sd32767);
    send_command(-16'sd32768, -16'sd32768);
    send_command(16'sd8192, 16'sd4096);
  endtask

  // Inverted range, equal bounds, zero and full trim, write to the unused index
  task automatic test_register_extremes();
    configure(1023, 0, 32767, 1'b0);
    send_command(16'sd16384, 16'sd0);
    send_command(16'sd4096, 16'sd2048);
    send_command(16'sd0, -16'sd8192);
    send_command(-16'sd1, 16'sd1);
    configure(512, 512, 0, 1'b0);
    send_command(16'sd16384, 16'sd8192);
    send_command(-16'sd16384, -16'sd4096);
    send_command(16'sd0, 16'sd16384);
    configure(0, 0, 16384, 1'b1);
    send_command(16'sd12000, -16'sd3000);
    send_command(-16'sd32768, 16'sd32767);
  endtask

  // Random commands over several register settings with bursts of idling
  task automatic test_random_mix();
    int min_duty, max_duty, trim;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: begin min_duty = 0; max_duty = 1023; trim = 32767; end
        1: begin
          min_duty = $urandom_range(600, 1023);
          max_duty = $urandom_range(0, 400);
          trim     = $urandom_range(0, 32767);
        end
        2: begin min_duty = 1023; max_duty = 1023; trim = 16384; end
        default: begin
          min_duty = $urandom_range(0, 400);
          max_duty = $urandom_range(600, 1023);
          trim     = $urandom_range(8192, 24576);
        end
      endcase
      configure(min_duty, max_duty, trim, $urandom_range(0, 1));
      for (int n = 0; n < PHASE_COMMANDS; n++) begin
        if (n % 20 == 0) begin
          cmd_gaps_on   = $urandom_range(0, 2) != 0;
          pwm_stalls_on = $urandom_range(0, 2) != 0;
        end
        send_random_command();
      end
    end
  endtask

  // Back-to-back commands with the result side always ready
  task automatic test_steady_stream();
    configure($urandom_range(0, 300), $urandom_range(700, 1023),
              $urandom_range(0, 32767), 1'b0);
    cmd_gaps_on   = 1'b0;
    pwm_stalls_on = 1'b0;
    repeat (STREAM_COMMANDS) send_random_command();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst            <= 1'b1;
    cmd_if.valid   <= 1'b0;
    cmd_if.speed_y <= '0;
    cmd_if.turn_x  <= '0;
    cfg_if.valid   <= 1'b0;
    cfg_if.index   <= CFG_PWM_MIN;
    cfg_if.data    <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_register_extremes();
    test_random_mix();
    test_steady_stream();

    drain_commands();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d drive commands across %0d register settings; %0d duty sets checked,",
             commands_sent, settings_applied + 1, duties_checked);
    $display("covering spin, mixing with normalization, inverted ranges and trim saturation.");
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
